// File: hw/rtl/hais_pkg.sv
package hais_pkg;

	localparam int unsigned CNT_W = 11;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned SMP_W = 12;
	localparam int unsigned CFG_DATA_W = 12;
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;
	localparam logic [CNT_W-1:0] FILE_CNT_MAX = 11'd1024;

	typedef enum logic [1:0] {
		MODE_FREE = 2'd0,
		MODE_REC  = 2'd1,
		MODE_PLAY = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_PERIOD = 3'd0,
		CFG_REPEAT_PAUSE  = 3'd1,
		CFG_HOLD_FIRST    = 3'd2,
		CFG_HOLD_SECOND   = 3'd3,
		CFG_HOLD_THIRD    = 3'd4,
		CFG_MODE_LOW      = 3'd5,
		CFG_MODE_HIGH     = 3'd6,
		CFG_FILE_COUNT    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]        sample_period;
		logic [9:0]        repeat_pause;
		logic [CNT_W-1:0]  hold_first;
		logic [CNT_W-1:0]  hold_second;
		logic [CNT_W-1:0]  hold_third;
		logic [SMP_W-1:0]  mode_low_limit;
		logic [SMP_W-1:0]  mode_high_limit;
		logic [CNT_W-1:0]  file_count;
	} cfg_t;

	typedef struct packed {
		logic              up_pressed;
		logic              down_pressed;
		logic [SMP_W-1:0]  switch_sample;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  file_index;
		mode_t             mode;
		logic              index_changed;
		logic              mode_changed;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0]  poll_countdown;
		logic              up_last;
		logic              down_last;
		logic [CNT_W-1:0]  up_hold_time;
		logic [CNT_W-1:0]  down_hold_time;
		logic [IDX_W-1:0]  index_value;
		mode_t             mode_value;
	} state_t;

endpackage

// File: hw/rtl/hais_if.sv
interface hais_item_if;
	import hais_pkg::*;
	logic              valid;
	logic              ready;
	logic              up_pressed;
	logic              down_pressed;
	logic [SMP_W-1:0]  switch_sample;

	modport source (output valid, up_pressed, down_pressed, switch_sample, input ready);
	modport sink (input valid, up_pressed, down_pressed, switch_sample, output ready);
endinterface

interface hais_res_if;
	import hais_pkg::*;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  file_index;
	logic [1:0]        mode;
	logic              index_changed;
	logic              mode_changed;

	modport source (output valid, file_index, mode, index_changed, mode_changed, input ready);
	modport sink (input valid, file_index, mode, index_changed, mode_changed, output ready);
endinterface

// File: hw/rtl/hais_cfg.sv
module hais_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hais_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [hais_pkg::CFG_DATA_W-1:0]    cfg_data,
	output hais_pkg::cfg_t                     cfg
);
	import hais_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_period   <= 8'd20;
			cfg_q.repeat_pause    <= 10'd120;
			cfg_q.hold_first      <= 11'd250;
			cfg_q.hold_second     <= 11'd750;
			cfg_q.hold_third      <= 11'd1250;
			cfg_q.mode_low_limit  <= 12'd1000;
			cfg_q.mode_high_limit <= 12'd3096;
			cfg_q.file_count      <= 11'd1002;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_SAMPLE_PERIOD: cfg_q.sample_period   <= cfg_data[7:0];
				CFG_REPEAT_PAUSE:  cfg_q.repeat_pause    <= cfg_data[9:0];
				CFG_HOLD_FIRST:    cfg_q.hold_first      <= cfg_data[CNT_W-1:0];
				CFG_HOLD_SECOND:   cfg_q.hold_second     <= cfg_data[CNT_W-1:0];
				CFG_HOLD_THIRD:    cfg_q.hold_third      <= cfg_data[CNT_W-1:0];
				CFG_MODE_LOW:      cfg_q.mode_low_limit  <= cfg_data;
				CFG_MODE_HIGH:     cfg_q.mode_high_limit <= cfg_data;
				CFG_FILE_COUNT:    cfg_q.file_count      <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// File: hw/rtl/hais_step.sv
module hais_step (
	input  hais_pkg::state_t st,
	input  hais_pkg::item_t  it,
	input  hais_pkg::cfg_t   cfg,
	output hais_pkg::state_t st_nxt,
	output hais_pkg::res_t   res
);
	import hais_pkg::*;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + 11'd1;
	endfunction

	function automatic logic [3:0] repeat_size(input logic [CNT_W-1:0] held);
		logic [3:0] s;
		if (held > cfg.hold_third)       s = 4'd10;
		else if (held > cfg.hold_second) s = 4'd5;
		else if (held > cfg.hold_first)  s = 4'd1;
		else                             s = 4'd0;
		return s;
	endfunction

	function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] v0,
			input logic signed [4:0] s, input logic [CNT_W-1:0] cnt);
		logic signed [11:0] v;
		logic [IDX_W-1:0]   r;
		v = $signed({2'b00, v0}) + $signed({{7{s[4]}}, s});
		if (v[11])                      r = 10'(cnt - 11'd1);
		else if (v[CNT_W-1:0] >= cnt)   r = '0;
		else                            r = v[IDX_W-1:0];
		return r;
	endfunction

	logic [CNT_W-1:0]   up_h, down_h, cnt;
	logic               poll, up_edge, down_edge, up_rep, down_rep;
	logic [3:0]         up_sz, down_sz;
	logic signed [4:0]  up_step, down_step;
	logic [7:0]         sp_eff;
	logic [11:0]        reload;
	logic               apply_en;
	logic [IDX_W-1:0]   idx1, idx2;
	mode_t              mode_new;

	always_comb begin
		up_h   = sat_inc(st.up_hold_time);
		down_h = sat_inc(st.down_hold_time);
		poll   = (st.poll_countdown == '0);

		up_edge   = poll && it.up_pressed && !st.up_last;
		down_edge = poll && it.down_pressed && !st.down_last;
		up_sz     = repeat_size(up_h);
		down_sz   = repeat_size(down_h);
		up_rep    = poll && it.up_pressed && st.up_last && (up_sz != '0);
		down_rep  = poll && it.down_pressed && st.down_last && (down_sz != '0);

		up_step   = up_edge ? 5'sd1 : (up_rep ? $signed({1'b0, up_sz}) : 5'sd0);
		down_step = down_edge ? -5'sd1 : (down_rep ? -$signed({1'b0, down_sz}) : 5'sd0);

		sp_eff = (cfg.sample_period == '0) ? 8'd1 : cfg.sample_period;
		reload = {4'd0, sp_eff - 8'd1}
			+ (up_rep ? {2'd0, cfg.repeat_pause} : 12'd0)
			+ (down_rep ? {2'd0, cfg.repeat_pause} : 12'd0);

		if (cfg.file_count == '0)             cnt = 11'd1;
		else if (cfg.file_count > FILE_CNT_MAX) cnt = FILE_CNT_MAX;
		else                                  cnt = cfg.file_count;

		apply_en = (st.mode_value != MODE_REC);
		idx1 = (apply_en && up_step != 0) ? wrap(st.index_value, up_step, cnt)
			: st.index_value;
		idx2 = (apply_en && down_step != 0) ? wrap(idx1, down_step, cnt) : idx1;

		if (it.switch_sample < cfg.mode_low_limit)       mode_new = MODE_FREE;
		else if (it.switch_sample > cfg.mode_high_limit) mode_new = MODE_PLAY;
		else                                             mode_new = MODE_REC;

		st_nxt.up_hold_time   = up_edge ? '0 : up_h;
		st_nxt.down_hold_time = down_edge ? '0 : down_h;
		st_nxt.up_last        = poll ? it.up_pressed : st.up_last;
		st_nxt.down_last      = poll ? it.down_pressed : st.down_last;
		if (poll)
			st_nxt.poll_countdown = (reload > {1'b0, CNT_MAX}) ? CNT_MAX : reload[CNT_W-1:0];
		else
			st_nxt.poll_countdown = st.poll_countdown - 11'd1;
		st_nxt.index_value = idx2;
		st_nxt.mode_value  = mode_new;

		res.file_index    = idx2;
		res.mode          = mode_new;
		res.index_changed = apply_en && (up_step != 0 || down_step != 0);
		res.mode_changed  = (mode_new != st.mode_value);
	end
endmodule

// File: hw/rtl/hold_accelerated_index_selector.sv
// Hold-accelerated index selector.
// items (sink): one request per 1 ms tick carrying the up/down button levels
// and the 12-bit mode switch sample. results (source): one request per tick
// with the file index, mode, index_changed and mode_changed.
// cfg_we/cfg_idx/cfg_data: register writes, taken at any edge with cfg_we high;
// write only while no tick is in flight.
// Path from item acceptance to result valid: input register, then result
// register. Throughput: one tick per cycle unless a stalled result holds the
// input register; the tick state is updated in the same cycle its result is
// registered, so back-to-back ticks see each other's state.
// A stalled result holds in the result register; one more tick can sit in the
// input register, after which items.ready drops until results.ready returns.
// Reset clears all tick state (countdown 0 so the first tick polls, buttons
// released, hold times 0, index 0, free mode) and loads register defaults.
module hold_accelerated_index_selector (
	input  logic                            clk,
	input  logic                            arst_n,
	hais_item_if.sink                       items,
	hais_res_if.source                      results,
	input  logic                            cfg_we,
	input  logic [hais_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [hais_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hais_pkg::*;

	cfg_t   cfg;
	item_t  item_s1;
	logic   valid_s1;
	state_t state_q, state_nxt;
	res_t   res_c, res_q;
	logic   res_valid_q;
	logic   adv_s1;

	hais_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	hais_step u_step (
		.st     (state_q),
		.it     (item_s1),
		.cfg    (cfg),
		.st_nxt (state_nxt),
		.res    (res_c)
	);

	assign adv_s1      = valid_s1 && (!res_valid_q || results.ready);
	assign items.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1.up_pressed    <= items.up_pressed;
			item_s1.down_pressed  <= items.down_pressed;
			item_s1.switch_sample <= items.switch_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{poll_countdown: '0, up_last: 1'b0, down_last: 1'b0,
				up_hold_time: '0, down_hold_time: '0, index_value: '0,
				mode_value: MODE_FREE};
			res_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (adv_s1) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_c;
		end
	end

	assign results.valid         = res_valid_q;
	assign results.file_index    = res_q.file_index;
	assign results.mode          = res_q.mode;
	assign results.index_changed = res_q.index_changed;
	assign results.mode_changed  = res_q.mode_changed;

`ifndef SYNTHESIS
	a_rec_holds_index: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && state_q.mode_value == MODE_REC |=> state_q.index_value == $past(state_q.index_value))
		else $error("index moved in record mode");

	a_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && state_q.poll_countdown != '0
		|=> state_q.poll_countdown == $past(state_q.poll_countdown) - 11'd1)
		else $error("poll countdown did not step");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> res_valid_q && res_q.file_index == state_q.index_value
		&& res_q.mode == state_q.mode_value)
		else $error("result out of step with state");

	a_idle_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("state changed without a tick");
`endif
endmodule
